// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL of the channel function block.
// Bodies compile away when SYNTHESIS is defined; expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define ASSERT_CHK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ===== hw/rtl/cfa_pkg.sv =====
// Types, codes and microcode program of the channel function activation block.
// No dependencies; used by cfa_useq and channel_function_activation.
`default_nettype none
package cfa_pkg;

  localparam int PcW = 5;
  typedef logic [PcW-1:0] upc_t;

  // input word modes
  localparam logic [1:0] MODE_WR_OWN   = 2'd0;
  localparam logic [1:0] MODE_WR_LINK  = 2'd1;
  localparam logic [1:0] MODE_WR_VALUE = 2'd2;
  localparam logic [1:0] MODE_QUERY    = 2'd3;

  // master link kinds
  localparam logic [1:0] LINK_NONE    = 2'd0;
  localparam logic [1:0] LINK_INVALID = 2'd1;
  localparam logic [1:0] LINK_CHAIN   = 2'd2;
  localparam logic [1:0] LINK_OTHER   = 2'd3;

  // configuration register indexes
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 9;
  localparam logic [CfgIdxW-1:0] CFG_FUNCTION_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SOURCE_COUNT   = 2'd1;

  typedef struct packed {
    logic [31:0] id;
    logic [8:0]  src;
    logic [31:0] lo;
    logic [31:0] hi;
  } own_entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] id;
    logic [31:0] lo;
    logic [31:0] hi;
  } link_entry_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_INIT_QUERY,
    OP_SCAN,
    OP_SET_CUR,
    OP_RD_CUR,
    OP_LATCH_CUR,
    OP_INIT_LINK,
    OP_RD_FOUND,
    OP_LATCH_SRC,
    OP_NEXT_LEVEL,
    OP_ANSWER_0,
    OP_ANSWER_1
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_SCAN_BUSY,
    C_NO_HIT,
    C_DEPTH_OVER,
    C_RANGE_FAIL,
    C_KIND_INVALID,
    C_KIND_NONE,
    C_KIND_NOT_CHAIN
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    upc_t  target;
  } ctl_word_t;

  typedef struct packed {
    logic scan_busy;
    logic no_hit;
    logic depth_over;
    logic range_fail;
    logic kind_invalid;
    logic kind_none;
    logic kind_not_chain;
  } cond_flags_t;

  // program addresses
  localparam upc_t U_INIT       = 5'd0;
  localparam upc_t U_SCAN_ID    = 5'd1;
  localparam upc_t U_TEST_ID    = 5'd2;
  localparam upc_t U_SET_CUR    = 5'd3;
  localparam upc_t U_LEVEL      = 5'd4;
  localparam upc_t U_RD_CUR     = 5'd5;
  localparam upc_t U_LATCH_CUR  = 5'd6;
  localparam upc_t U_OWN_RANGE  = 5'd7;
  localparam upc_t U_KIND_BAD   = 5'd8;
  localparam upc_t U_KIND_NONE  = 5'd9;
  localparam upc_t U_INIT_LINK  = 5'd10;
  localparam upc_t U_SCAN_LINK  = 5'd11;
  localparam upc_t U_TEST_LINK  = 5'd12;
  localparam upc_t U_RD_MASTER  = 5'd13;
  localparam upc_t U_LATCH_MSRC = 5'd14;
  localparam upc_t U_MST_RANGE  = 5'd15;
  localparam upc_t U_KIND_CHAIN = 5'd16;
  localparam upc_t U_NEXT       = 5'd17;
  localparam upc_t U_FAIL       = 5'd18;
  localparam upc_t U_PASS       = 5'd19;

  function automatic ctl_word_t ucode_rom(input upc_t pc);
    ctl_word_t w;
    w = '{op: OP_ANSWER_0, cond: C_NEVER, target: U_FAIL};
    unique case (pc)
      U_INIT:       w = '{op: OP_INIT_QUERY, cond: C_NEVER,          target: U_INIT};
      U_SCAN_ID:    w = '{op: OP_SCAN,       cond: C_SCAN_BUSY,      target: U_SCAN_ID};
      U_TEST_ID:    w = '{op: OP_NOP,        cond: C_NO_HIT,         target: U_FAIL};
      U_SET_CUR:    w = '{op: OP_SET_CUR,    cond: C_NEVER,          target: U_INIT};
      U_LEVEL:      w = '{op: OP_NOP,        cond: C_DEPTH_OVER,     target: U_FAIL};
      U_RD_CUR:     w = '{op: OP_RD_CUR,     cond: C_NEVER,          target: U_INIT};
      U_LATCH_CUR:  w = '{op: OP_LATCH_CUR,  cond: C_NEVER,          target: U_INIT};
      U_OWN_RANGE:  w = '{op: OP_NOP,        cond: C_RANGE_FAIL,     target: U_FAIL};
      U_KIND_BAD:   w = '{op: OP_NOP,        cond: C_KIND_INVALID,   target: U_FAIL};
      U_KIND_NONE:  w = '{op: OP_NOP,        cond: C_KIND_NONE,      target: U_PASS};
      U_INIT_LINK:  w = '{op: OP_INIT_LINK,  cond: C_NEVER,          target: U_INIT};
      U_SCAN_LINK:  w = '{op: OP_SCAN,       cond: C_SCAN_BUSY,      target: U_SCAN_LINK};
      U_TEST_LINK:  w = '{op: OP_NOP,        cond: C_NO_HIT,         target: U_FAIL};
      U_RD_MASTER:  w = '{op: OP_RD_FOUND,   cond: C_NEVER,          target: U_INIT};
      U_LATCH_MSRC: w = '{op: OP_LATCH_SRC,  cond: C_NEVER,          target: U_INIT};
      U_MST_RANGE:  w = '{op: OP_NOP,        cond: C_RANGE_FAIL,     target: U_FAIL};
      U_KIND_CHAIN: w = '{op: OP_NOP,        cond: C_KIND_NOT_CHAIN, target: U_PASS};
      U_NEXT:       w = '{op: OP_NEXT_LEVEL, cond: C_ALWAYS,         target: U_LEVEL};
      U_FAIL:       w = '{op: OP_ANSWER_0,   cond: C_NEVER,          target: U_FAIL};
      U_PASS:       w = '{op: OP_ANSWER_1,   cond: C_NEVER,          target: U_PASS};
      default:      w = '{op: OP_ANSWER_0,   cond: C_NEVER,          target: U_FAIL};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module cfa_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/cfa_useq.sv =====
// Microcode sequencer: step counter, program ROM from cfa_pkg, conditional jumps.
// Depends on cfa_pkg.
`default_nettype none
module cfa_useq
  import cfa_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        run_i,
  input  cond_flags_t      flags_i,
  output op_e              op_o
);

  upc_t      pc_q, pc_d;
  ctl_word_t word;
  logic      take;

  always_comb begin
    word = ucode_rom(pc_q);
    unique case (word.cond)
      C_NEVER:          take = 1'b0;
      C_ALWAYS:         take = 1'b1;
      C_SCAN_BUSY:      take = flags_i.scan_busy;
      C_NO_HIT:         take = flags_i.no_hit;
      C_DEPTH_OVER:     take = flags_i.depth_over;
      C_RANGE_FAIL:     take = flags_i.range_fail;
      C_KIND_INVALID:   take = flags_i.kind_invalid;
      C_KIND_NONE:      take = flags_i.kind_none;
      C_KIND_NOT_CHAIN: take = flags_i.kind_not_chain;
      default:          take = 1'b0;
    endcase
  end

  always_comb begin
    pc_d = pc_q;
    if (start_i) begin
      pc_d = U_INIT;
    end else if (run_i) begin
      pc_d = take ? word.target : pc_q + 1'b1;
    end
  end

  assign op_o = word.op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= U_INIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/channel_function_activation.sv =====
// Channel function activation: the answer to a write word is registered at the next edge.
// Query: walks the master levels; each id search reads the entry RAM once per cycle over
// the entries in use. One query at a time; a new word is taken as the result leaves.
// Reset clears the counts and control state; the tables are undefined until written.
`default_nettype none
`include "assert_macros.svh"
module channel_function_activation
  import cfa_pkg::*;
#(
  parameter int ENTRIES = 64,
  parameter int SOURCES = 256
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [1:0]          mode_i,
  input  wire logic [7:0]          slot_i,
  input  wire logic signed [31:0]  function_id_i,
  input  wire logic signed [8:0]   source_index_i,
  input  wire logic [31:0]         low_value_i,
  input  wire logic [31:0]         high_value_i,
  input  wire logic [1:0]          link_kind_i,
  input  wire logic signed [31:0]  link_id_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     active_o
);

  localparam int EAW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SAW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int CW  = $clog2(ENTRIES + 1);
  localparam int SCW = $clog2(SOURCES + 1);
  localparam int DW  = $clog2(ENTRIES + 2);

  // configuration
  logic [6:0] fcount_q;
  logic [8:0] scount_q;
  logic [CW-1:0]  count_c;
  logic [SCW-1:0] scount_c;

  // handshake
  logic in_acc, is_query, start;
  logic busy_q, busy_d;
  logic out_valid_q, out_valid_d;
  logic active_q, active_d;

  // datapath
  logic [CW-1:0]  idx_q, idx_d;
  logic           rd_vld_q, rd_vld_d;
  logic [EAW-1:0] addr_q, addr_d;
  logic           hit_q, hit_d;
  logic [EAW-1:0] found_q, found_d;
  logic [EAW-1:0] cur_q, cur_d;
  logic [DW-1:0]  depth_q, depth_d;
  logic [31:0]    key_q, key_d;
  logic [31:0]    lo_q, lo_d, hi_q, hi_d;
  logic [31:0]    mlo_q, mlo_d, mhi_q, mhi_d;
  logic [31:0]    lid_q, lid_d;
  logic [1:0]     kind_q, kind_d;
  logic           src_ok_q, src_ok_d;

  // memories
  logic           own_we, link_we, val_we;
  logic [EAW+7:0] slot_e;
  logic [SAW+7:0] slot_s;
  logic [SAW+7:0] src_s;
  logic [EAW-1:0] own_raddr;
  logic [SAW-1:0] val_raddr;
  own_entry_t     own_wdata, own_rdata;
  link_entry_t    link_wdata, link_rdata;
  logic [31:0]    val_rdata;

  op_e            op;
  cond_flags_t    flags;
  logic           scan_hit, scan_end, src_ok_c;

  assign count_c  = (32'(fcount_q) > ENTRIES) ? CW'(ENTRIES) : CW'(fcount_q);
  assign scount_c = (32'(scount_q) > SOURCES) ? SCW'(SOURCES) : SCW'(scount_q);

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !busy_q && (!out_valid_q || out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;
  assign is_query    = (mode_i == MODE_QUERY);
  assign start       = in_acc && is_query;

  // table writes
  assign slot_e  = (EAW + 8)'(slot_i);
  assign slot_s  = (SAW + 8)'(slot_i);
  assign own_we  = in_acc && (mode_i == MODE_WR_OWN) && (32'(slot_i) < ENTRIES);
  assign link_we = in_acc && (mode_i == MODE_WR_LINK) && (32'(slot_i) < ENTRIES);
  assign val_we  = in_acc && (mode_i == MODE_WR_VALUE) && (32'(slot_i) < SOURCES);
  assign own_wdata  = '{id: function_id_i, src: source_index_i, lo: low_value_i,
                        hi: high_value_i};
  assign link_wdata = '{kind: link_kind_i, id: link_id_i, lo: low_value_i, hi: high_value_i};

  always_comb begin
    unique case (op)
      OP_SCAN:     own_raddr = idx_q[EAW-1:0];
      OP_RD_FOUND: own_raddr = found_q;
      default:     own_raddr = cur_q;
    endcase
  end

  // channel index of whichever entry was read last
  assign src_s     = (SAW + 8)'(own_rdata.src[7:0]);
  assign val_raddr = src_s[SAW-1:0];
  assign src_ok_c  = !own_rdata.src[8] && (32'(own_rdata.src[7:0]) < 32'(scount_c));

  cfa_ram #(.Width($bits(own_entry_t)), .Depth(ENTRIES)) u_own_ram (
    .clk_i   (clk_i),
    .we_i    (own_we),
    .waddr_i (slot_e[EAW-1:0]),
    .wdata_i (own_wdata),
    .raddr_i (own_raddr),
    .rdata_o (own_rdata)
  );

  cfa_ram #(.Width($bits(link_entry_t)), .Depth(ENTRIES)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (slot_e[EAW-1:0]),
    .wdata_i (link_wdata),
    .raddr_i (cur_q),
    .rdata_o (link_rdata)
  );

  cfa_ram #(.Width(32), .Depth(SOURCES)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (slot_s[SAW-1:0]),
    .wdata_i (low_value_i),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  // scan: one address issued per cycle, id compared on the registered read data
  assign scan_hit = rd_vld_q && (own_rdata.id == key_q);
  assign scan_end = !rd_vld_q && !(idx_q < count_c);

  assign flags.scan_busy      = !scan_hit && !scan_end;
  assign flags.no_hit         = !hit_q;
  assign flags.depth_over     = 32'(depth_q) > 32'(count_c);
  assign flags.range_fail     = !src_ok_q || (val_rdata < lo_q) || (val_rdata > hi_q);
  assign flags.kind_invalid   = (kind_q == LINK_INVALID);
  assign flags.kind_none      = (kind_q == LINK_NONE);
  assign flags.kind_not_chain = (kind_q != LINK_CHAIN);

  cfa_useq u_useq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .run_i   (busy_q),
    .flags_i (flags),
    .op_o    (op)
  );

  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q && !out_ready_i;
    active_d    = active_q;
    idx_d       = idx_q;
    rd_vld_d    = rd_vld_q;
    addr_d      = addr_q;
    hit_d       = hit_q;
    found_d     = found_q;
    cur_d       = cur_q;
    depth_d     = depth_q;
    key_d       = key_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mlo_d       = mlo_q;
    mhi_d       = mhi_q;
    lid_d       = lid_q;
    kind_d      = kind_q;
    src_ok_d    = src_ok_q;

    if (in_acc) begin
      if (is_query) begin
        busy_d = 1'b1;
        key_d  = function_id_i;
      end else begin
        out_valid_d = 1'b1;
        active_d    = 1'b0;
      end
    end

    if (busy_q) begin
      unique case (op)
        OP_INIT_QUERY: begin
          idx_d    = '0;
          rd_vld_d = 1'b0;
          depth_d  = '0;
        end
        OP_SCAN: begin
          hit_d   = scan_hit;
          found_d = addr_q;
          if (idx_q < count_c) begin
            rd_vld_d = 1'b1;
            addr_d   = idx_q[EAW-1:0];
            idx_d    = idx_q + 1'b1;
          end else begin
            rd_vld_d = 1'b0;
          end
        end
        OP_SET_CUR: cur_d = found_q;
        OP_LATCH_CUR: begin
          src_ok_d = src_ok_c;
          lo_d     = own_rdata.lo;
          hi_d     = own_rdata.hi;
          kind_d   = link_rdata.kind;
          lid_d    = link_rdata.id;
          mlo_d    = link_rdata.lo;
          mhi_d    = link_rdata.hi;
        end
        OP_INIT_LINK: begin
          idx_d    = '0;
          rd_vld_d = 1'b0;
          key_d    = lid_q;
          lo_d     = mlo_q;
          hi_d     = mhi_q;
        end
        OP_LATCH_SRC: src_ok_d = src_ok_c;
        OP_NEXT_LEVEL: begin
          cur_d   = found_q;
          depth_d = depth_q + 1'b1;
        end
        OP_ANSWER_0, OP_ANSWER_1: begin
          busy_d      = 1'b0;
          out_valid_d = 1'b1;
          active_d    = (op == OP_ANSWER_1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcount_q    <= '0;
      scount_q    <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      idx_q       <= '0;
      depth_q     <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_FUNCTION_COUNT) begin
          fcount_q <= cfg_data_i[6:0];
        end else if (cfg_index_i == CFG_SOURCE_COUNT) begin
          scount_q <= cfg_data_i;
        end
      end
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      rd_vld_q    <= rd_vld_d;
      hit_q       <= hit_d;
      idx_q       <= idx_d;
      depth_q     <= depth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    active_q <= active_d;
    addr_q   <= addr_d;
    found_q  <= found_d;
    cur_q    <= cur_d;
    key_q    <= key_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mlo_q    <= mlo_d;
    mhi_q    <= mhi_d;
    lid_q    <= lid_d;
    kind_q   <= kind_d;
    src_ok_q <= src_ok_d;
  end

  assign out_valid_o = out_valid_q;
  assign active_o    = active_q;

  `ASSERT_NEVER(a_answer_on_full, busy_q && (op == OP_ANSWER_0 || op == OP_ANSWER_1) && out_valid_q, "query answer would overwrite a waiting word")
  `ASSERT_CHK(a_query_starts, start |=> busy_q && !out_valid_q, "query accepted but sequencer not running")
  `ASSERT_CHK(a_depth_bound, busy_q |-> 32'(depth_q) <= 32'(count_c) + 32'd1, "walk depth beyond entry count")
  `ASSERT_CHK(a_write_answer, (in_acc && !is_query) |=> out_valid_o && !active_o, "write word did not give an inactive answer")

endmodule
`default_nettype wire
